// ===== rtl/coapfp_pkg.sv =====
package coapfp_pkg;

   // CSR port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_VERSION = 1'b0;  // paddr[2] selects the register
   localparam logic [1:0] VERSION_RESET = 2'd1;

   // Frame format constants
   localparam logic [7:0]  MARKER_BYTE     = 8'hff;
   localparam logic [3:0]  EXT_CODE_8      = 4'd13;
   localparam logic [3:0]  EXT_CODE_16     = 4'd14;
   localparam logic [3:0]  NIBBLE_RESERVED = 4'd15;
   localparam logic [16:0] EXT_OFFSET_8    = 17'd13;
   localparam logic [16:0] EXT_OFFSET_16   = 17'd269;
   localparam logic [15:0] HEADER_END_POS  = 16'd6;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_TOKEN    = 3'd1,
      KIND_OPTSTART = 3'd2,
      KIND_OPTBYTE  = 3'd3,
      KIND_PAYLOAD  = 3'd4,
      KIND_OK       = 3'd5,
      KIND_ERROR    = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      ERR_VERSION   = 3'd0,
      ERR_NIBBLE    = 3'd1,
      ERR_NO_MARKER = 3'd2,
      ERR_NUMBER    = 3'd3,
      ERR_TRUNCATED = 3'd4
   } err_type;

   typedef enum logic [10:0] {
      PH_IDLE    = 11'b000_0000_0001,
      PH_LEN_LO  = 11'b000_0000_0010,
      PH_HEADER  = 11'b000_0000_0100,
      PH_TOKEN   = 11'b000_0000_1000,
      PH_OPT_HDR = 11'b000_0001_0000,
      PH_DEXT_A  = 11'b000_0010_0000,
      PH_DEXT_B  = 11'b000_0100_0000,
      PH_LEXT_A  = 11'b000_1000_0000,
      PH_LEXT_B  = 11'b001_0000_0000,
      PH_VALUE   = 11'b010_0000_0000,
      PH_PAYLOAD = 11'b100_0000_0000
   } phase_type;

   // One result word
   typedef struct packed {
      kind_type    kind;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  msg_code;
      logic [15:0] msg_id;
      logic [15:0] frame_length;
      logic [15:0] option_number;
      logic [16:0] option_length;
      logic [7:0]  out_byte;
      logic [2:0]  error_code;
      logic        is_last;
   } rsp_type;

   // Up to two result words produced by one input word
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ===== rtl/coap_frame_parser.sv =====
// Byte-serial CoAP frame parser. Each frame is a 2-byte big-endian length
// (counting the prefix itself), the 4-byte header, token, options and an
// optional 0xff marker with payload; req_frame_start marks the first length
// byte. The block returns one rsp word per header, token byte, option start
// (accumulated number and decoded length), option value byte and payload
// byte, and closes each frame not cut off by a new frame start with an ok or
// error word. Throughput is one byte per cycle while the result queue has
// room: a byte is held in the input register, is parsed in a single pass and
// lands in a four-word result queue, from which its first word is valid on
// rsp. A byte is taken whenever the input register is empty or the queue has
// two free slots, the most one byte can produce. The expected version lives
// at CSR address 0 (reset value 1); write it only while the block is idle.
module coap_frame_parser (
   input  logic                               clock,
   input  logic                               reset,
   // input words
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_data_byte,
   input  logic                               req_frame_start,
   // result words
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_kind,
   output logic [1:0]                         rsp_msg_type,
   output logic [3:0]                         rsp_token_length,
   output logic [7:0]                         rsp_msg_code,
   output logic [15:0]                        rsp_msg_id,
   output logic [15:0]                        rsp_frame_length,
   output logic [15:0]                        rsp_option_number,
   output logic [16:0]                        rsp_option_length,
   output logic [7:0]                         rsp_out_byte,
   output logic [2:0]                         rsp_error_code,
   output logic                               rsp_is_last,
   // CSR port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [coapfp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [coapfp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [coapfp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                               pready
);
   import coapfp_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic [1:0]  version_ff;
   logic        step_en;
   logic        room;
   push_type    push;
   rsp_type     rsp;

   // CSR access
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_VERSION) ?
                   {{(CSR_DATA_W-2){1'b0}}, version_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= VERSION_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[2] == CSR_IDX_VERSION) begin
         version_ff <= pwdata[1:0];
      end
   end

   // Input register: refilled in the cycle it drains
   assign step_en     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || room;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
   end

   coapfp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step_en          (step_en),
      .data_byte        (in_byte_ff),
      .frame_start      (in_start_ff),
      .expected_version (version_ff),
      .push             (push)
   );

   coapfp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Result fields
   assign rsp_kind          = rsp.kind;
   assign rsp_msg_type      = rsp.msg_type;
   assign rsp_token_length  = rsp.token_length;
   assign rsp_msg_code      = rsp.msg_code;
   assign rsp_msg_id        = rsp.msg_id;
   assign rsp_frame_length  = rsp.frame_length;
   assign rsp_option_number = rsp.option_number;
   assign rsp_option_length = rsp.option_length;
   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_error_code    = rsp.error_code;
   assign rsp_is_last       = rsp.is_last;

endmodule

// ===== rtl/coapfp_parser.sv =====
module coapfp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           data_byte,
   input  logic                 frame_start,
   input  logic [1:0]           expected_version,
   output coapfp_pkg::push_type push
);
   import coapfp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] mlen_ff, mlen_in;
   logic [15:0] onum_ff, onum_in;
   logic [3:0]  dcode_ff, dcode_in;
   logic [3:0]  lcode_ff, lcode_in;
   logic [7:0]  ext_ff, ext_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] hdr_ff, hdr_in;

   logic        data_vld;
   rsp_type     data_rsp;
   logic        vd_vld;
   logic        vd_ok;
   err_type     vd_err;
   rsp_type     vd_rsp;

   // Step logic: one byte against the current parse state
   always_comb begin
      logic [15:0] pos_inc;
      logic        at_end;
      logic        do_delta;
      logic        do_after;
      logic        do_finish;
      logic [16:0] delta;
      logic [17:0] sum;
      logic [16:0] fin_len;
      logic [7:0]  b0;

      phase_in = phase_ff;
      pos_in   = pos_ff;
      mlen_in  = mlen_ff;
      onum_in  = onum_ff;
      dcode_in = dcode_ff;
      lcode_in = lcode_ff;
      ext_in   = ext_ff;
      rem_in   = rem_ff;
      hdr_in   = hdr_ff;

      pos_inc   = pos_ff + 16'd1;
      at_end    = (pos_inc == mlen_ff);
      data_vld  = 1'b0;
      data_rsp  = '0;
      vd_vld    = 1'b0;
      vd_ok     = 1'b0;
      vd_err    = ERR_VERSION;
      do_delta  = 1'b0;
      do_after  = 1'b0;
      do_finish = 1'b0;
      delta     = '0;
      sum       = '0;
      fin_len   = '0;
      b0        = hdr_ff[23:16];

      if (frame_start) begin
         mlen_in  = {data_byte, 8'h00};
         pos_in   = 16'd1;
         onum_in  = '0;
         hdr_in   = '0;
         phase_in = PH_LEN_LO;
      end else if (phase_ff != PH_IDLE) begin
         pos_in = pos_inc;
         case (phase_ff)
            PH_LEN_LO: begin
               mlen_in  = mlen_ff | {8'h00, data_byte};
               phase_in = PH_HEADER;
            end
            PH_HEADER: begin
               hdr_in = {hdr_ff[23:0], data_byte};
               if (pos_inc == HEADER_END_POS) begin
                  if (b0[7:6] != expected_version) begin
                     vd_vld = 1'b1;
                     vd_err = ERR_VERSION;
                  end else if ({1'b0, mlen_ff} <
                               ({1'b0, HEADER_END_POS} + {13'd0, b0[3:0]})) begin
                     vd_vld = 1'b1;
                     vd_err = ERR_TRUNCATED;
                  end else begin
                     data_vld              = 1'b1;
                     data_rsp.kind         = KIND_HEADER;
                     data_rsp.msg_type     = b0[5:4];
                     data_rsp.token_length = b0[3:0];
                     data_rsp.msg_code     = hdr_ff[15:8];
                     data_rsp.msg_id       = {hdr_ff[7:0], data_byte};
                     data_rsp.frame_length = mlen_ff;
                     if (b0[3:0] != 4'd0) begin
                        rem_in   = {13'd0, b0[3:0]};
                        phase_in = PH_TOKEN;
                     end else if (at_end) begin
                        vd_vld = 1'b1;
                        vd_ok  = 1'b1;
                     end else begin
                        phase_in = PH_OPT_HDR;
                     end
                  end
               end
            end
            PH_TOKEN: begin
               data_vld          = 1'b1;
               data_rsp.kind     = KIND_TOKEN;
               data_rsp.out_byte = data_byte;
               rem_in            = rem_ff - 17'd1;
               if (rem_in == '0) begin
                  if (at_end) begin
                     vd_vld = 1'b1;
                     vd_ok  = 1'b1;
                  end else begin
                     phase_in = PH_OPT_HDR;
                  end
               end
            end
            PH_OPT_HDR: begin
               if (data_byte == MARKER_BYTE) begin
                  if (at_end) begin
                     vd_vld = 1'b1;
                     vd_ok  = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  dcode_in = data_byte[7:4];
                  lcode_in = data_byte[3:0];
                  if (data_byte[7:4] == NIBBLE_RESERVED ||
                      data_byte[3:0] == NIBBLE_RESERVED) begin
                     vd_vld = 1'b1;
                     vd_err = ERR_NIBBLE;
                  end else if (data_byte[7:4] inside {EXT_CODE_8, EXT_CODE_16}) begin
                     if (at_end) begin
                        vd_vld = 1'b1;
                        vd_err = ERR_NO_MARKER;
                     end else begin
                        phase_in = PH_DEXT_A;
                     end
                  end else begin
                     do_delta = 1'b1;
                     delta    = {13'd0, data_byte[7:4]};
                  end
               end
            end
            PH_DEXT_A: begin
               if (dcode_ff == EXT_CODE_8) begin
                  do_delta = 1'b1;
                  delta    = {9'd0, data_byte} + EXT_OFFSET_8;
               end else begin
                  ext_in = data_byte;
                  if (at_end) begin
                     vd_vld = 1'b1;
                     vd_err = ERR_NO_MARKER;
                  end else begin
                     phase_in = PH_DEXT_B;
                  end
               end
            end
            PH_DEXT_B: begin
               do_delta = 1'b1;
               delta    = {1'b0, ext_ff, data_byte} + EXT_OFFSET_16;
            end
            PH_LEXT_A: begin
               if (lcode_ff == EXT_CODE_8) begin
                  do_finish = 1'b1;
                  fin_len   = {9'd0, data_byte} + EXT_OFFSET_8;
               end else begin
                  ext_in = data_byte;
                  if (at_end) begin
                     vd_vld = 1'b1;
                     vd_err = ERR_NO_MARKER;
                  end else begin
                     phase_in = PH_LEXT_B;
                  end
               end
            end
            PH_LEXT_B: begin
               do_finish = 1'b1;
               fin_len   = {1'b0, ext_ff, data_byte} + EXT_OFFSET_16;
            end
            PH_VALUE: begin
               data_vld          = 1'b1;
               data_rsp.kind     = KIND_OPTBYTE;
               data_rsp.out_byte = data_byte;
               rem_in            = rem_ff - 17'd1;
               if (rem_in == '0) begin
                  if (at_end) begin
                     vd_vld = 1'b1;
                     vd_ok  = 1'b1;
                  end else begin
                     phase_in = PH_OPT_HDR;
                  end
               end else if (at_end) begin
                  vd_vld = 1'b1;
                  vd_err = ERR_NO_MARKER;
               end
            end
            PH_PAYLOAD: begin
               data_vld          = 1'b1;
               data_rsp.kind     = KIND_PAYLOAD;
               data_rsp.out_byte = data_byte;
               if (at_end) begin
                  vd_vld = 1'b1;
                  vd_ok  = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // Accumulate option number; overflow past 16 bits is an error
         if (do_delta) begin
            sum = {2'b00, onum_ff} + {1'b0, delta};
            if (sum[17:16] != 2'b00) begin
               vd_vld = 1'b1;
               vd_err = ERR_NUMBER;
            end else begin
               onum_in  = sum[15:0];
               do_after = 1'b1;
            end
         end

         // Length code: extension bytes or immediate option start
         if (do_after) begin
            if (lcode_in inside {EXT_CODE_8, EXT_CODE_16}) begin
               if (at_end) begin
                  vd_vld = 1'b1;
                  vd_err = ERR_NO_MARKER;
               end else begin
                  phase_in = PH_LEXT_A;
               end
            end else begin
               do_finish = 1'b1;
               fin_len   = {13'd0, lcode_in};
            end
         end

         // Option start word, then value bytes or next option
         if (do_finish) begin
            data_vld               = 1'b1;
            data_rsp.kind          = KIND_OPTSTART;
            data_rsp.option_number = onum_in;
            data_rsp.option_length = fin_len;
            if (fin_len == '0) begin
               if (at_end) begin
                  vd_vld = 1'b1;
                  vd_ok  = 1'b1;
               end else begin
                  phase_in = PH_OPT_HDR;
               end
            end else begin
               rem_in = fin_len;
               if (at_end) begin
                  vd_vld = 1'b1;
                  vd_err = ERR_NO_MARKER;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
         end

         if (vd_vld) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Verdict word
   always_comb begin
      vd_rsp            = '0;
      vd_rsp.kind       = vd_ok ? KIND_OK : KIND_ERROR;
      vd_rsp.error_code = vd_ok ? 3'd0 : vd_err;
   end

   // Order the words: data word first, verdict closes
   always_comb begin
      push        = '0;
      push.first  = data_vld ? data_rsp : vd_rsp;
      push.second = vd_rsp;
      if (step_en) begin
         push.count = {1'b0, data_vld} + {1'b0, vd_vld};
      end
      if (data_vld && vd_vld) begin
         push.second.is_last = 1'b1;
      end else begin
         push.first.is_last = 1'b1;
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step_en) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         pos_ff   <= pos_in;
         mlen_ff  <= mlen_in;
         onum_ff  <= onum_in;
         dcode_ff <= dcode_in;
         lcode_ff <= lcode_in;
         ext_ff   <= ext_in;
         rem_ff   <= rem_in;
         hdr_ff   <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   // a second word in one step is always the verdict
   assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |->
      (push.second.kind == KIND_OK || push.second.kind == KIND_ERROR))
      else $error("second word of a step is not a verdict");

   assert property (@(posedge clock) reset |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after reset");

   // frame start always moves to the low length byte
   assert property (@(posedge clock) disable iff (reset)
      (step_en && frame_start) |=> (phase_ff == PH_LEN_LO))
      else $error("frame start did not restart the parser");
`endif

endmodule

// ===== rtl/coapfp_rsp_fifo.sv =====
module coapfp_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  coapfp_pkg::push_type push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output coapfp_pkg::rsp_type  rsp
);
   import coapfp_pkg::*;

   rsp_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]     count_ff, count_in;
   logic                   pop;

   // room for the widest step (two words)
   assign room      = (count_ff <= (RSP_PTR_W+1)'(RSP_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp       = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + (RSP_PTR_W+1)'(push.count) - (RSP_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage: one or two words per push
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.second;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (RSP_PTR_W+1)'(RSP_DEPTH))
      else $error("result queue overflow");

   // the parser only steps when two slots are free
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("push without room");

   // a waiting word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
      else $error("result word changed while waiting");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import coapfp_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HALF_PHASE = 165;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] VERSION_ADDR = {CSR_IDX_VERSION, 2'b00};

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } rx_byte_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // DUT ports
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [1:0]  rsp_msg_type;
   logic [3:0]  rsp_token_length;
   logic [7:0]  rsp_msg_code;
   logic [15:0] rsp_msg_id;
   logic [15:0] rsp_frame_length;
   logic [15:0] rsp_option_number;
   logic [16:0] rsp_option_length;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_error_code;
   logic        rsp_is_last;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   coap_frame_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_msg_type      (rsp_msg_type),
      .rsp_token_length  (rsp_token_length),
      .rsp_msg_code      (rsp_msg_code),
      .rsp_msg_id        (rsp_msg_id),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_option_number (rsp_option_number),
      .rsp_option_length (rsp_option_length),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_error_code    (rsp_error_code),
      .rsp_is_last       (rsp_is_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // shared testbench state
   rx_byte_type byte_fifo[$];
   rx_byte_type next_item;
   rsp_type    expected_words[$];
   rsp_type    step_words[$];
   logic [7:0] frame_body[$];
   int         send_gap_pct = 14;
   int         recv_stall_pct = 87;
   bit         long_hold_go = 1'b0;
   bit         long_hold_done = 1'b0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   int         fails = 0;

   // parser shadow state
   logic [1:0]  cfg_version = VERSION_RESET;
   phase_type   ps_phase = PH_IDLE;
   logic [15:0] ps_pos = '0;
   logic [15:0] ps_len = '0;
   logic [16:0] ps_optnum = '0;
   logic [3:0]  ps_dcode = '0;
   logic [3:0]  ps_lcode = '0;
   logic [7:0]  ps_exthi = '0;
   logic [16:0] ps_left = '0;
   logic [31:0] ps_hdr = '0;

   // queue helpers
   task automatic emit_word(input rsp_type w);
      step_words.insert(step_words.size(), w);
   endtask

   task automatic body_byte(input logic [7:0] v);
      frame_body.insert(frame_body.size(), v);
   endtask

   function automatic bit frame_done();
      return ps_pos == ps_len;
   endfunction

   task automatic close_ok();
      rsp_type w;
      w = '0;
      w.kind = KIND_OK;
      emit_word(w);
      ps_phase = PH_IDLE;
   endtask

   task automatic close_err(input err_type code);
      rsp_type w;
      w = '0;
      w.kind = KIND_ERROR;
      w.error_code = code;
      emit_word(w);
      ps_phase = PH_IDLE;
   endtask

   // returns 1 when the option number would pass 16 bits
   function automatic bit bump_number(input logic [16:0] delta);
      logic [17:0] sum;
      sum = {1'b0, ps_optnum} + {1'b0, delta};
      if (sum > 18'h0ffff) return 1'b1;
      ps_optnum = sum[16:0];
      return 1'b0;
   endfunction

   task automatic option_done(input logic [16:0] olen);
      rsp_type w;
      w = '0;
      w.kind = KIND_OPTSTART;
      w.option_number = ps_optnum[15:0];
      w.option_length = olen;
      emit_word(w);
      if (olen == 17'd0) begin
         if (frame_done()) close_ok();
         else ps_phase = PH_OPT_HDR;
      end else begin
         ps_left = olen;
         if (frame_done()) close_err(ERR_NO_MARKER);
         else ps_phase = PH_VALUE;
      end
   endtask

   // delta is settled, now the length nibble
   task automatic length_stage();
      if (ps_lcode >= EXT_CODE_8) begin
         if (frame_done()) close_err(ERR_NO_MARKER);
         else ps_phase = PH_LEXT_A;
      end else begin
         option_done(17'(ps_lcode));
      end
   endtask

   // expected result words for one accepted byte
   task automatic parse_expect(input logic [7:0] b, input logic start);
      rsp_type w;
      step_words.delete();
      if (start) begin
         ps_len = {b, 8'h00};
         ps_pos = 16'd1;
         ps_optnum = '0;
         ps_hdr = '0;
         ps_phase = PH_LEN_LO;
      end else if (ps_phase != PH_IDLE) begin
         ps_pos = ps_pos + 16'd1;
         case (ps_phase)
            PH_LEN_LO: begin
               ps_len = ps_len | {8'h00, b};
               ps_phase = PH_HEADER;
            end
            PH_HEADER: begin
               ps_hdr = {ps_hdr[23:0], b};
               if (ps_pos == HEADER_END_POS) begin
                  if (ps_hdr[31:30] != cfg_version) begin
                     close_err(ERR_VERSION);
                  end else if (ps_len < 16'd6 + 16'(ps_hdr[27:24])) begin
                     close_err(ERR_TRUNCATED);
                  end else begin
                     w = '0;
                     w.kind = KIND_HEADER;
                     w.msg_type = ps_hdr[29:28];
                     w.token_length = ps_hdr[27:24];
                     w.msg_code = ps_hdr[23:16];
                     w.msg_id = ps_hdr[15:0];
                     w.frame_length = ps_len;
                     emit_word(w);
                     if (ps_hdr[27:24] != 4'd0) begin
                        ps_left = 17'(ps_hdr[27:24]);
                        ps_phase = PH_TOKEN;
                     end else if (frame_done()) begin
                        close_ok();
                     end else begin
                        ps_phase = PH_OPT_HDR;
                     end
                  end
               end
            end
            PH_TOKEN: begin
               w = '0;
               w.kind = KIND_TOKEN;
               w.out_byte = b;
               emit_word(w);
               ps_left = ps_left - 17'd1;
               if (ps_left == 17'd0) begin
                  if (frame_done()) close_ok();
                  else ps_phase = PH_OPT_HDR;
               end
            end
            PH_OPT_HDR: begin
               if (b == MARKER_BYTE) begin
                  if (frame_done()) close_ok();
                  else ps_phase = PH_PAYLOAD;
               end else begin
                  ps_dcode = b[7:4];
                  ps_lcode = b[3:0];
                  if (ps_dcode == NIBBLE_RESERVED || ps_lcode == NIBBLE_RESERVED) begin
                     close_err(ERR_NIBBLE);
                  end else if (ps_dcode >= EXT_CODE_8) begin
                     if (frame_done()) close_err(ERR_NO_MARKER);
                     else ps_phase = PH_DEXT_A;
                  end else if (bump_number(17'(ps_dcode))) begin
                     close_err(ERR_NUMBER);
                  end else begin
                     length_stage();
                  end
               end
            end
            PH_DEXT_A: begin
               if (ps_dcode == EXT_CODE_8) begin
                  if (bump_number(17'(b) + EXT_OFFSET_8)) close_err(ERR_NUMBER);
                  else length_stage();
               end else begin
                  ps_exthi = b;
                  if (frame_done()) close_err(ERR_NO_MARKER);
                  else ps_phase = PH_DEXT_B;
               end
            end
            PH_DEXT_B: begin
               if (bump_number({1'b0, ps_exthi, b} + EXT_OFFSET_16)) close_err(ERR_NUMBER);
               else length_stage();
            end
            PH_LEXT_A: begin
               if (ps_lcode == EXT_CODE_8) begin
                  option_done(17'(b) + EXT_OFFSET_8);
               end else begin
                  ps_exthi = b;
                  if (frame_done()) close_err(ERR_NO_MARKER);
                  else ps_phase = PH_LEXT_B;
               end
            end
            PH_LEXT_B: begin
               option_done({1'b0, ps_exthi, b} + EXT_OFFSET_16);
            end
            PH_VALUE: begin
               w = '0;
               w.kind = KIND_OPTBYTE;
               w.out_byte = b;
               emit_word(w);
               ps_left = ps_left - 17'd1;
               if (ps_left == 17'd0) begin
                  if (frame_done()) close_ok();
                  else ps_phase = PH_OPT_HDR;
               end else if (frame_done()) begin
                  close_err(ERR_NO_MARKER);
               end
            end
            PH_PAYLOAD: begin
               w = '0;
               w.kind = KIND_PAYLOAD;
               w.out_byte = b;
               emit_word(w);
               if (frame_done()) close_ok();
            end
            default: ps_phase = PH_IDLE;
         endcase
      end
      // flag the closing word of this byte, then queue them all
      if (step_words.size() > 0) begin
         w = step_words[step_words.size() - 1];
         w.is_last = 1'b1;
         step_words[step_words.size() - 1] = w;
      end
      foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
      step_words.delete();
   endtask

   // input word driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_expect(req_data_byte, req_frame_start);
         if (!req_valid || req_ready) begin
            if (byte_fifo.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               next_item = byte_fifo[0];
               byte_fifo.delete(0);
               req_valid <= 1'b1;
               req_data_byte <= next_item.data;
               req_frame_start <= next_item.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fails++;
      end
   endtask

   task automatic check_word();
      rsp_type want;
      if (expected_words.size() == 0) begin
         $error("result word with nothing expected: kind %0d", rsp_kind);
         fails++;
      end else begin
         want = expected_words[0];
         expected_words.delete(0);
         check_field("kind", 32'(want.kind), 32'(rsp_kind));
         check_field("msg_type", 32'(want.msg_type), 32'(rsp_msg_type));
         check_field("token_length", 32'(want.token_length), 32'(rsp_token_length));
         check_field("msg_code", 32'(want.msg_code), 32'(rsp_msg_code));
         check_field("msg_id", 32'(want.msg_id), 32'(rsp_msg_id));
         check_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
         check_field("option_number", 32'(want.option_number), 32'(rsp_option_number));
         check_field("option_length", 32'(want.option_length), 32'(rsp_option_length));
         check_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
         check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
         check_field("is_last", 32'(want.is_last), 32'(rsp_is_last));
      end
   endtask

   // result word monitor, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[coap_frame_parser] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put(input logic [7:0] data, input logic start);
      rx_byte_type item;
      item.data = data;
      item.start = start;
      byte_fifo.insert(byte_fifo.size(), item);
   endtask

   // one option: header byte, delta extension, length extension, value bytes
   task automatic add_option();
      int unsigned dsel, lsel, vlen, d_n, l_n;
      logic [3:0]  dcode, lcode;
      logic [15:0] d_ext, l_ext;
      d_ext = '0;
      l_ext = '0;
      dsel = $urandom_range(0, 9);
      if (dsel < 6) begin
         dcode = 4'($urandom_range(0, 12));
         d_n = 0;
      end else if (dsel < 8) begin
         dcode = EXT_CODE_8;
         d_n = 1;
         d_ext = 16'($urandom_range(0, 255));
      end else if (dsel == 8) begin
         dcode = EXT_CODE_16;
         d_n = 2;
         d_ext = 16'($urandom_range(0, 600));
      end else begin
         // full 16-bit extension, which can drive the number past 16 bits
         dcode = EXT_CODE_16;
         d_n = 2;
         d_ext = 16'($urandom);
      end
      lsel = $urandom_range(0, 9);
      if (lsel < 7) begin
         lcode = 4'($urandom_range(0, 12));
         l_n = 0;
         vlen = lcode;
      end else if (lsel < 9) begin
         lcode = EXT_CODE_8;
         l_n = 1;
         l_ext = 16'($urandom_range(0, 4));
         vlen = 13 + l_ext;
      end else begin
         // long value: only a few bytes follow, the frame ends inside it
         lcode = EXT_CODE_16;
         l_n = 2;
         l_ext = 16'($urandom);
         vlen = $urandom_range(0, 8);
      end
      body_byte({dcode, lcode});
      if (d_n == 2) body_byte(d_ext[15:8]);
      if (d_n >= 1) body_byte(d_ext[7:0]);
      if (l_n == 2) body_byte(l_ext[15:8]);
      if (l_n >= 1) body_byte(l_ext[7:0]);
      repeat (vlen) body_byte(8'($urandom));
   endtask

   // one random frame, mostly well formed, sometimes broken
   task automatic queue_frame(inout int count);
      int unsigned tkl, keep, mode, i;
      logic [1:0]  ver;
      logic [15:0] flen;
      frame_body.delete();
      ver = ($urandom_range(0, 7) == 0) ? 2'($urandom) : cfg_version;
      tkl = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 4);
      body_byte({ver, 2'($urandom), 4'(tkl)});
      repeat (3 + tkl) body_byte(8'($urandom));
      repeat ($urandom_range(0, 3)) add_option();
      case ($urandom_range(0, 9))
         0: begin
            if ($urandom_range(0, 1) == 0)
               body_byte({NIBBLE_RESERVED, 4'($urandom)});
            else
               body_byte({4'($urandom_range(0, 14)), NIBBLE_RESERVED});
         end
         1, 2, 3: ;
         default: begin
            body_byte(MARKER_BYTE);
            repeat ($urandom_range(0, 6)) body_byte(8'($urandom));
         end
      endcase
      flen = 16'(frame_body.size() + 2);
      keep = frame_body.size();
      mode = $urandom_range(0, 11);
      if (mode == 0) begin
         // length ends somewhere inside the frame
         flen = 16'($urandom_range(6, flen));
         keep = flen - 2;
      end else if (mode == 1) begin
         // length too short for header plus token
         flen = 16'($urandom_range(0, 5 + tkl));
         keep = 4;
      end else if (mode == 2) begin
         // cut off, abandoned by the next frame start
         keep = $urandom_range(0, keep);
      end else if (mode == 3) begin
         // claims more bytes than it carries
         flen = 16'($urandom_range(flen, 65535));
      end
      put(flen[15:8], 1'b1);
      put(flen[7:0], 1'b0);
      for (i = 0; i < keep; i++) put(frame_body[i], 1'b0);
      count += 2 + keep;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) put(8'($urandom), 1'b0);
      end
   endtask

   // wait until nothing is queued, in flight or expected, then settle
   task automatic wait_drained();
      @(negedge clock);
      while (byte_fifo.size() > 0 || req_valid || expected_words.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_version(input logic [1:0] v);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= VERSION_ADDR;
      pwdata <= {30'($urandom), v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cfg_version = v;
   endtask

   // stimulus sequence
   initial begin
      logic [1:0] versions[4];
      int sent;
      versions = '{2'd0, 2'd3, 2'd2, 2'd1};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset version
      put(8'hff, 1'b0);
      // smallest frame, all-ones code and id
      put(8'h00, 1'b1); put(8'h06, 1'b0);
      put(8'h40, 1'b0); put(8'hff, 1'b0); put(8'hff, 1'b0); put(8'hff, 1'b0);
      // abandoned start, then token byte and a reserved nibble
      put(8'hff, 1'b1);
      put(8'h00, 1'b1); put(8'h0a, 1'b0);
      put(8'h41, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
      put(8'haa, 1'b0); put(8'hf0, 1'b0);
      // marker as the final byte
      put(8'h00, 1'b1); put(8'h07, 1'b0);
      put(8'h70, 1'b0); put(8'h00, 1'b0); put(8'h12, 1'b0); put(8'h34, 1'b0);
      put(MARKER_BYTE, 1'b0);
      // length shorter than header plus token
      put(8'h00, 1'b1); put(8'h05, 1'b0);
      put(8'h48, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
      wait_drained();

      // random phases, one version setting each
      for (int p = 0; p < 4; p++) begin
         write_version(versions[p]);
         if (p == 0) begin
            send_gap_pct = 14;
            recv_stall_pct = 87;
         end else if (p == 1) begin
            send_gap_pct = 87;
            recv_stall_pct = 14;
         end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         if (p == 2) long_hold_go = 1'b1;
         sent = 0;
         while (sent < HALF_PHASE) queue_frame(sent);
         wait_drained();
         sent = 0;
         while (sent < HALF_PHASE) queue_frame(sent);
         wait_drained();
      end

      if (fails == 0 && expected_words.size() == 0) begin
         $display("[coap_frame_parser] OK");
      end else begin
         $display("[coap_frame_parser] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/coapfp_pkg.sv
rtl/coapfp_parser.sv
rtl/coapfp_rsp_fifo.sv
rtl/coap_frame_parser.sv
sim/tb_top.sv
